// ===== rtl/jse_pkg.sv =====
// Shared types, constants and helpers for the JSON string escape encoder.
package jse_pkg;

	localparam int MaxBytes = 12;
	localparam int CntW     = 4;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_UNIT  = 2'd1,
		ACT_END   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
	localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
	localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;
	localparam logic [15:0] CTRL_LIMIT   = 16'h0020;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [15:0] CU_QUOTE = 16'h0022;
	localparam logic [15:0] CU_BSL   = 16'h005C;
	localparam logic [15:0] CU_BS    = 16'h0008;
	localparam logic [15:0] CU_FF    = 16'h000C;
	localparam logic [15:0] CU_LF    = 16'h000A;
	localparam logic [15:0] CU_CR    = 16'h000D;
	localparam logic [15:0] CU_TAB   = 16'h0009;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [CntW-1:0]          count;
		logic                     held_valid;
		logic [15:0]              held_high;
	} enc_t;

	// lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
	endfunction

	// backslash, u, four hex digits; element 0 goes out first
	function automatic logic [5:0][7:0] hex_seq(input logic [15:0] v);
		logic [5:0][7:0] s;
		s[0] = CH_BSL;
		s[1] = CH_U;
		s[2] = hex_char(v[15:12]);
		s[3] = hex_char(v[11:8]);
		s[4] = hex_char(v[7:4]);
		s[5] = hex_char(v[3:0]);
		hex_seq = s;
	endfunction

endpackage

// ===== rtl/jse_encode.sv =====
// Combinational escape and UTF-8 encoding of one item into a byte run.
module jse_encode import jse_pkg::*; (
	input  logic [1:0]  action,
	input  logic [15:0] code_unit,
	input  logic        held_valid,
	input  logic [15:0] held_high,
	output enc_t        enc
);

	logic [5:0][7:0] m;
	logic [5:0][7:0] hx_held;
	logic [5:0][7:0] hx_unit;
	logic [2:0]      mcnt;
	logic            flush;
	logic            is_high;
	logic            is_low;
	logic [20:0]     cp;

	assign is_high = (code_unit >= SURR_HIGH_LO) && (code_unit <= SURR_HIGH_HI);
	assign is_low  = (code_unit >= SURR_LOW_LO) && (code_unit <= SURR_LOW_HI);
	assign cp      = {1'b0, held_high[9:0], code_unit[9:0]} + SUPP_BASE;
	assign hx_held = hex_seq(held_high);
	assign hx_unit = hex_seq(code_unit);

	always_comb begin
		m              = '0;
		mcnt           = 3'd0;
		flush          = 1'b0;
		enc.held_valid = held_valid;
		enc.held_high  = held_high;
		unique case (action_t'(action))
			ACT_BEGIN, ACT_END: begin
				flush          = held_valid;
				m[0]           = CH_QUOTE;
				mcnt           = 3'd1;
				enc.held_valid = 1'b0;
			end
			ACT_UNIT: begin
				enc.held_valid = 1'b0;
				if (held_valid && is_low) begin
					m[0] = {5'b11110, cp[20:18]};
					m[1] = {2'b10, cp[17:12]};
					m[2] = {2'b10, cp[11:6]};
					m[3] = {2'b10, cp[5:0]};
					mcnt = 3'd4;
				end else begin
					flush = held_valid;
					case (code_unit)
						CU_QUOTE: begin m[0] = CH_BSL; m[1] = CH_QUOTE; mcnt = 3'd2; end
						CU_BSL:   begin m[0] = CH_BSL; m[1] = CH_BSL;   mcnt = 3'd2; end
						CU_BS:    begin m[0] = CH_BSL; m[1] = CH_B;     mcnt = 3'd2; end
						CU_FF:    begin m[0] = CH_BSL; m[1] = CH_F;     mcnt = 3'd2; end
						CU_LF:    begin m[0] = CH_BSL; m[1] = CH_N;     mcnt = 3'd2; end
						CU_CR:    begin m[0] = CH_BSL; m[1] = CH_R;     mcnt = 3'd2; end
						CU_TAB:   begin m[0] = CH_BSL; m[1] = CH_T;     mcnt = 3'd2; end
						default: begin
							if (code_unit < CTRL_LIMIT || is_low) begin
								m    = hx_unit;
								mcnt = 3'd6;
							end else if (is_high) begin
								enc.held_valid = 1'b1;
								enc.held_high  = code_unit;
							end else if (code_unit < 16'h0080) begin
								m[0] = code_unit[7:0];
								mcnt = 3'd1;
							end else if (code_unit < 16'h0800) begin
								m[0] = {3'b110, code_unit[10:6]};
								m[1] = {2'b10, code_unit[5:0]};
								mcnt = 3'd2;
							end else begin
								m[0] = {4'b1110, code_unit[15:12]};
								m[1] = {2'b10, code_unit[11:6]};
								m[2] = {2'b10, code_unit[5:0]};
								mcnt = 3'd3;
							end
						end
					endcase
				end
			end
			default: ;
		endcase

		// an unpaired held surrogate goes first, the unit's own bytes follow it
		for (int i = 0; i < 6; i++) begin
			enc.bytes[i]     = flush ? hx_held[i] : m[i];
			enc.bytes[i + 6] = m[i];
		end
		enc.count = (flush ? CntW'(6) : CntW'(0)) + CntW'(mcnt);
	end

endmodule

// ===== rtl/json_string_escape_encoder_top.sv =====
// Top level of the JSON string escape encoder: item input, byte run buffer, byte output.
// Takes UTF-16 code units plus begin and end markers and gives a quoted, JSON-escaped
// UTF-8 byte stream, one byte per cycle on the byte channel while byte_ready is high;
// run_last marks the final byte caused by each item. Each item is encoded in the cycle
// it is accepted into a twelve-byte run register, which is then read out one byte a
// cycle while byte_ready is high, and the next item is taken in the cycle its last byte
// leaves: plain text runs at one unit per cycle when the byte channel does not stall,
// and items that yield nothing (a high surrogate held with none before it, or action
// 3) leave the run register empty, ready for the next item.
module json_string_escape_encoder_top import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_ready,
	input  logic [1:0]  action,
	input  logic [15:0] code_unit,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	enc_t                     enc;
	logic                     held_valid_q;
	logic [15:0]              held_high_q;
	logic [MaxBytes-1:0][7:0] bytes_s1;
	logic [CntW-1:0]          cnt_s1;
	logic [CntW-1:0]          idx_q;
	logic                     valid_q;
	logic                     last;
	logic                     unit_acc;
	logic                     byte_acc;

	jse_encode u_encode (
		.action     (action),
		.code_unit  (code_unit),
		.held_valid (held_valid_q),
		.held_high  (held_high_q),
		.enc        (enc)
	);

	assign last       = (idx_q == (cnt_s1 - CntW'(1)));
	assign byte_valid = valid_q;
	assign out_byte   = bytes_s1[idx_q];
	assign run_last   = last;
	assign byte_acc   = valid_q && byte_ready;
	assign unit_ready = !valid_q || (byte_ready && last);
	assign unit_acc   = unit_valid && unit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			idx_q        <= '0;
			held_valid_q <= 1'b0;
			held_high_q  <= '0;
		end else if (unit_acc) begin
			valid_q      <= (enc.count != '0);
			idx_q        <= '0;
			held_valid_q <= enc.held_valid;
			held_high_q  <= enc.held_high;
		end else if (byte_acc) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (unit_acc) begin
			bytes_s1 <= enc.bytes;
			cnt_s1   <= enc.count;
		end
	end

endmodule

// ===== rtl/jse_checker.sv =====
// Port-level checks for the JSON string escape encoder, bound to the top level.
module jse_checker import jse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        unit_valid,
	input logic        unit_ready,
	input logic [1:0]  action,
	input logic        byte_valid,
	input logic        byte_ready,
	input logic [7:0]  out_byte,
	input logic        run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(out_byte) && $stable(run_last))
		else $error("byte changed while stalled");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid |-> unit_ready)
		else $error("input not ready with empty output");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |-> !unit_ready)
		else $error("item taken over a stalled run");

	a_quote_out: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_ready && (action == ACT_BEGIN || action == ACT_END) |=> byte_valid)
		else $error("begin or end item gave no bytes");

	a_none_silent: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_ready && action == ACT_NONE |=> !byte_valid)
		else $error("unused action gave bytes");

endmodule

bind json_string_escape_encoder_top jse_checker u_jse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.unit_valid (unit_valid),
	.unit_ready (unit_ready),
	.action     (action),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.out_byte   (out_byte),
	.run_last   (run_last)
);
